// ===== rtl/bzm_pkg.sv =====
`default_nettype none

package bzm_pkg;

   // Block geometry
   localparam int MAX_SIDE    = 64;
   localparam int SIDE_W      = 7;
   localparam int N_W         = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int COUNT_W     = $clog2(MAX_SIDE * MAX_SIDE);

   // Pixel and accumulator widths
   localparam int GRAY_W      = 8;
   localparam int DIFF_W      = GRAY_W + 1;
   localparam int DIFF_SQ_W   = 2 * GRAY_W;
   localparam int DSUM_W      = 21;
   localparam int MAG_W       = DSUM_W - 1;
   localparam int SQ_W        = 28;

   // Distance arithmetic
   localparam int FRAC_BITS   = 8;
   localparam int PROD_W      = N_W + SQ_W;
   localparam int MAG_SQ_W    = 2 * MAG_W;
   localparam int NSQ_W       = 2 * N_W;
   localparam int DVD_W       = PROD_W + FRAC_BITS;
   localparam int DIV_CNT_W   = $clog2(DVD_W);
   localparam int OUT_W       = 24;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_HEIGHT = 1'b0,
      CSR_BLOCK_WIDTH  = 1'b1
   } csr_index_type;

   // Totals of one finished block, handed from front to back
   typedef struct packed {
      logic [N_W-1:0]           pair_total;
      logic signed [DSUM_W-1:0] diff_sum;
      logic [SQ_W-1:0]          diff_square_sum;
   } block_sums_type;

   typedef struct packed {
      logic           valid;
      block_sums_type sums;
   } sums_beat_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0] result;
      if (side == '0) begin
         result = SIDE_W'(1);
      end else if (32'(side) > MAX_SIDE) begin
         result = SIDE_W'(MAX_SIDE);
      end else begin
         result = side;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/block_zero_mean_ssd_unit.sv =====
`default_nettype none

// Zero-mean sum of squared differences between two equal-size gray blocks.
//
// Feed co-located pixel pairs in raster order on the req_ channel, one beat
// per pair. After block_height*block_width pairs (each side clamped to
// 1..64) one beat leaves on the rsp_ channel: the mean-removed squared
// distance per pair in unsigned Q16.8, truncated, saturating at 0xFFFFFF.
// Program the sides on the csr_ port (index 0 height, 1 width) between
// blocks or mid-block while nothing is in flight; a shrink mid-block closes
// the block on the next pair.
//
// The front takes one pair per cycle while the queue has room. Finished
// block totals go through a two-entry queue to the back, which does three
// multiplies, a subtract and a 49-step shift-subtract division (states
// MUL, SUB, DIV, OUT) before it registers the result beat. The back pops
// the next block only once it is idle again, so short blocks queue up.
// A stalled rsp_ beat holds in the output register while the back finishes
// the next block behind it; req_ready drops only when the queue is full.
// Reset (synchronous) clears the accumulators, empties the queue, drops
// rsp_valid and sets both sides to 8.

module block_zero_mean_ssd_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_write_enable,
   input  wire [bzm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [bzm_pkg::SIDE_W-1:0]          csr_write_data,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [bzm_pkg::GRAY_W-1:0]          req_first_gray,
   input  wire [bzm_pkg::GRAY_W-1:0]          req_second_gray,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [bzm_pkg::OUT_W-1:0]          rsp_distance_q8
);

   // Block totals from front into the queue, and the queue head to the back
   bzm_pkg::sums_beat_type push;
   bzm_pkg::sums_beat_type head;
   logic                   queue_full;
   logic                   pop;

   // Accumulate pairs; hold off the source when the queue has no room
   bzm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_gray   (req_first_gray),
      .req_second_gray  (req_second_gray),
      .queue_full       (queue_full),
      .push             (push)
   );

   // Decouple the pixel stream from the per-block division
   bzm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Form N*S2 - D^2, divide by N^2, register the result beat
   bzm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance_q8 (rsp_distance_q8)
   );

endmodule

`default_nettype wire

// ===== rtl/bzm_front.sv =====
`default_nettype none

module bzm_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_write_enable,
   input  wire [bzm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [bzm_pkg::SIDE_W-1:0]            csr_write_data,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire [bzm_pkg::GRAY_W-1:0]            req_first_gray,
   input  wire [bzm_pkg::GRAY_W-1:0]            req_second_gray,
   input  wire                                  queue_full,
   output bzm_pkg::sums_beat_type               push
);

   logic [bzm_pkg::SIDE_W-1:0]          height_ff, height_in;
   logic [bzm_pkg::SIDE_W-1:0]          width_ff, width_in;
   logic [bzm_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic signed [bzm_pkg::DSUM_W-1:0]   dsum_ff, dsum_in;
   logic [bzm_pkg::SQ_W-1:0]            sq_ff, sq_in;

   logic [bzm_pkg::N_W-1:0]             pair_total;
   logic [bzm_pkg::N_W-1:0]             count_next;
   logic signed [bzm_pkg::DIFF_W-1:0]   diff;
   logic signed [2*bzm_pkg::DIFF_W-1:0] diff_prod;
   logic [bzm_pkg::DIFF_SQ_W-1:0]       diff_sq;
   logic signed [bzm_pkg::DSUM_W-1:0]   dsum_next;
   logic [bzm_pkg::SQ_W-1:0]            sq_next;
   logic                                accept;
   logic                                block_done;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pair_total = bzm_pkg::N_W'(bzm_pkg::clamp_side(height_ff))
                 * bzm_pkg::N_W'(bzm_pkg::clamp_side(width_ff));
      diff       = $signed({1'b0, req_first_gray}) - $signed({1'b0, req_second_gray});
      diff_prod  = diff * diff;
      diff_sq    = diff_prod[bzm_pkg::DIFF_SQ_W-1:0];
      count_next = bzm_pkg::N_W'(count_ff) + bzm_pkg::N_W'(1);
      dsum_next  = dsum_ff + bzm_pkg::DSUM_W'(diff);
      sq_next    = sq_ff + bzm_pkg::SQ_W'(diff_sq);
      block_done = count_next >= pair_total;

      push.valid                = accept && block_done;
      push.sums.pair_total      = pair_total;
      push.sums.diff_sum        = dsum_next;
      push.sums.diff_square_sum = sq_next;

      height_in = height_ff;
      width_in  = width_ff;
      if (csr_write_enable) begin
         case (bzm_pkg::csr_index_type'(csr_index))
            bzm_pkg::CSR_BLOCK_HEIGHT: height_in = csr_write_data;
            bzm_pkg::CSR_BLOCK_WIDTH:  width_in  = csr_write_data;
            default: ;
         endcase
      end

      count_in = count_ff;
      dsum_in  = dsum_ff;
      sq_in    = sq_ff;
      if (accept) begin
         if (block_done) begin
            count_in = '0;
            dsum_in  = '0;
            sq_in    = '0;
         end else begin
            count_in = count_next[bzm_pkg::COUNT_W-1:0];
            dsum_in  = dsum_next;
            sq_in    = sq_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= bzm_pkg::SIDE_W'(8);
         width_ff  <= bzm_pkg::SIDE_W'(8);
         count_ff  <= '0;
         dsum_ff   <= '0;
         sq_ff     <= '0;
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         count_ff  <= count_in;
         dsum_ff   <= dsum_in;
         sq_ff     <= sq_in;
      end
   end

   // A block never runs past its pair total
   assert property (@(posedge clock) disable iff (reset)
      (bzm_pkg::N_W'(count_ff) < pair_total) || !accept || block_done)
      else $error("front: pair count ran past block size");

endmodule

`default_nettype wire

// ===== rtl/bzm_queue.sv =====
`default_nettype none

module bzm_queue (
   input  wire                            clock,
   input  wire                            reset,
   input  bzm_pkg::sums_beat_type         push,
   output logic                           full,
   output bzm_pkg::sums_beat_type         head,
   input  wire                            pop
);

   bzm_pkg::block_sums_type             slot_ff [bzm_pkg::QUEUE_DEPTH];
   logic [bzm_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [bzm_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [bzm_pkg::QCNT_W-1:0]          count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full       = count_ff == bzm_pkg::QCNT_W'(bzm_pkg::QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.sums  = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   function automatic logic [bzm_pkg::QPTR_W-1:0] next_ptr(
      input logic [bzm_pkg::QPTR_W-1:0] ptr);
      logic [bzm_pkg::QPTR_W-1:0] result;
      if (32'(ptr) == bzm_pkg::QUEUE_DEPTH - 1) begin
         result = '0;
      end else begin
         result = ptr + bzm_pkg::QPTR_W'(1);
      end
      return result;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + bzm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - bzm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.sums;
      end
   end

   // The front holds off when full, so no block total is ever dropped
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("queue: push while full");

   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= bzm_pkg::QUEUE_DEPTH)
      else $error("queue: occupancy above depth");

endmodule

`default_nettype wire

// ===== rtl/bzm_back.sv =====
`default_nettype none

module bzm_back (
   input  wire                          clock,
   input  wire                          reset,
   input  bzm_pkg::sums_beat_type       head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [bzm_pkg::OUT_W-1:0]    rsp_distance_q8
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_SUB,
      B_DIV,
      B_OUT
   } back_state_type;

   back_state_type                       state_ff, state_in;
   logic [bzm_pkg::N_W-1:0]              n_ff, n_in;
   logic signed [bzm_pkg::DSUM_W-1:0]    dsum_ff, dsum_in;
   logic [bzm_pkg::SQ_W-1:0]             sq_ff, sq_in;
   logic [bzm_pkg::PROD_W-1:0]           prod_a_ff, prod_a_in;
   logic [bzm_pkg::MAG_SQ_W-1:0]         prod_b_ff, prod_b_in;
   logic [bzm_pkg::NSQ_W-1:0]            nsq_ff, nsq_in;
   logic [bzm_pkg::DVD_W-1:0]            dvd_ff, dvd_in;
   logic [bzm_pkg::NSQ_W-1:0]            rem_ff, rem_in;
   logic [bzm_pkg::DIV_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [bzm_pkg::OUT_W-1:0]            out_data_ff, out_data_in;

   logic [bzm_pkg::MAG_W-1:0]            mag;
   logic [bzm_pkg::PROD_W-1:0]           numer;
   logic [bzm_pkg::NSQ_W-1:0]            trial;
   logic                                 fits;

   assign rsp_valid       = out_valid_ff;
   assign rsp_distance_q8 = out_data_ff;

   always_comb begin
      mag   = dsum_ff[bzm_pkg::DSUM_W-1] ? bzm_pkg::MAG_W'(-dsum_ff)
                                         : bzm_pkg::MAG_W'(dsum_ff);
      numer = (prod_a_ff >= bzm_pkg::PROD_W'(prod_b_ff))
            ? prod_a_ff - bzm_pkg::PROD_W'(prod_b_ff) : '0;
      trial = {rem_ff[bzm_pkg::NSQ_W-2:0], dvd_ff[bzm_pkg::DVD_W-1]};
      fits  = trial >= nsq_ff;

      state_in     = state_ff;
      n_in         = n_ff;
      dsum_in      = dsum_ff;
      sq_in        = sq_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      nsq_in       = nsq_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      pop          = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               n_in     = head.sums.pair_total;
               dsum_in  = head.sums.diff_sum;
               sq_in    = head.sums.diff_square_sum;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_a_in = bzm_pkg::PROD_W'(n_ff) * bzm_pkg::PROD_W'(sq_ff);
            prod_b_in = bzm_pkg::MAG_SQ_W'(mag) * bzm_pkg::MAG_SQ_W'(mag);
            nsq_in    = bzm_pkg::NSQ_W'(n_ff) * bzm_pkg::NSQ_W'(n_ff);
            state_in  = B_SUB;
         end
         B_SUB: begin
            // Scale by 2^8 for the fraction bits
            dvd_in   = {numer, bzm_pkg::FRAC_BITS'(0)};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            // One quotient bit per cycle; quotient shifts in behind the dividend
            rem_in = fits ? trial - nsq_ff : trial;
            dvd_in = {dvd_ff[bzm_pkg::DVD_W-2:0], fits};
            cnt_in = cnt_ff + bzm_pkg::DIV_CNT_W'(1);
            if (32'(cnt_ff) == bzm_pkg::DVD_W - 1) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = (|dvd_ff[bzm_pkg::DVD_W-1:bzm_pkg::OUT_W])
                            ? '1 : dvd_ff[bzm_pkg::OUT_W-1:0];
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      dsum_ff     <= dsum_in;
      sq_ff       <= sq_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      nsq_ff      <= nsq_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      out_data_ff <= out_data_in;
   end

   // Divisor is a square of a clamped block size, never zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (nsq_ff != '0))
      else $error("back: zero divisor");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (32'(cnt_ff) < bzm_pkg::DVD_W))
      else $error("back: divide step count overran");

   // Remainder stays below the divisor throughout the division
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) && (cnt_ff != '0) |-> (rem_ff < nsq_ff))
      else $error("back: remainder not reduced");

endmodule

`default_nettype wire
